@@ src/rgbpi_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbpi_pkg: shared types and constants for the RGB555 palette index search
// Holds the palette size, field widths, command codes and the record that
// travels from cell to cell along the search chain.
// ----------------------------------------------------------------------------
package rgbpi_pkg;

  // Number of palette slots, one cell per slot.
  localparam int PALETTE_ENTRIES = 256;

  // Field widths fixed by the interface.
  localparam int IDX_W   = 8;
  localparam int CH_W    = 8;
  localparam int SQ_W    = 2 * CH_W;
  // Largest squared distance is 3*255*255 = 195075, which fits in 18 bits.
  localparam int DIST_W  = SQ_W + 2;
  localparam int COLOR_W = 15;
  localparam int Q_W     = 5;

  // Starting best distance; larger than any real distance.
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  // Request commands.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Request contents. For a query the colour fields carry the widened
  // query colour; for a write they carry the new palette entry.
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] slot;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } item_t;

  // Record handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    item_t             item;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } link_t;

endpackage

@@ src/rgb555_to_palette_index_core.sv @@
// ----------------------------------------------------------------------------
// rgb555_to_palette_index_core: nearest palette colour search
// A chain of palette cells that maps RGB555 colours to palette indices.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid / req_stall. With cmd at CMD_WRITE a request
// stores red, green and blue into the slot given by entry_index and gives no
// response. With cmd at CMD_QUERY the 15-bit colour15 (red in bits 0-4,
// green 5-9, blue 10-14) is widened to 8 bits per channel as value*8+4 and
// the lowest slot at the least squared RGB distance is returned on
// res_valid / res_stall as nearest_index.
// Every request walks the whole chain of 256 cells, two register stages per
// cell, and then the response register before a query answers. Requests
// are taken one per cycle while req_stall is low and are handled strictly
// in order, so a query sees every earlier write. When the receiver stalls
// with a response waiting, the whole chain holds and req_stall rises in the
// same cycle. Reset clears every palette entry to zero and empties the
// chain; a query then answers slot 0.
// ----------------------------------------------------------------------------
module rgb555_to_palette_index_core
  import rgbpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               cmd,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [CH_W-1:0]    red,
  input  logic [CH_W-1:0]    green,
  input  logic [CH_W-1:0]    blue,
  input  logic [COLOR_W-1:0] color15,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [IDX_W-1:0]   nearest_index
);

  link_t links [PALETTE_ENTRIES+1];
  link_t tail;
  logic  advance;

  // The chain moves whenever the response register is free or being taken.
  assign advance   = !res_valid || !res_stall;
  assign req_stall = !advance;

  // Head of the chain: widen a query colour, pass a write as it is.
  always_comb begin
    links[0].valid     = req_valid;
    links[0].item.cmd  = cmd_t'(cmd);
    links[0].item.slot = entry_index;
    links[0].best_dist = DIST_INIT;
    links[0].best_idx  = '0;
    if (cmd_t'(cmd) == CMD_QUERY) begin
      links[0].item.red   = {color15[Q_W-1:0], 3'b100};
      links[0].item.green = {color15[2*Q_W-1:Q_W], 3'b100};
      links[0].item.blue  = {color15[3*Q_W-1:2*Q_W], 3'b100};
    end else begin
      links[0].item.red   = red;
      links[0].item.green = green;
      links[0].item.blue  = blue;
    end
  end

  // One cell per palette slot.
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    rgbpi_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (IDX_W'(k)),
      .link_in    (links[k]),
      .link_out   (links[k+1])
    );
  end

  assign tail = links[PALETTE_ENTRIES];

  // Response register: only queries leave a response.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= tail.valid && (tail.item.cmd == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nearest_index <= tail.best_idx;
    end
  end

endmodule

@@ src/rgbpi_cell.sv @@
// ----------------------------------------------------------------------------
// rgbpi_cell: one palette slot of the search chain
// Stores one palette colour. A write request for this slot updates it; a
// query request picks up this slot if it is strictly nearer than the best
// seen so far. Two register stages: squares, then sum and compare.
// ----------------------------------------------------------------------------
module rgbpi_cell
  import rgbpi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [IDX_W-1:0] cell_index,
  input  link_t            link_in,
  output link_t            link_out
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // Stored palette colour.
  logic [CH_W-1:0] entry_red;
  logic [CH_W-1:0] entry_green;
  logic [CH_W-1:0] entry_blue;

  // First stage: squared channel differences and the passing record.
  logic              a_valid;
  item_t             a_item;
  logic [DIST_W-1:0] a_best_dist;
  logic [IDX_W-1:0]  a_best_idx;
  logic [SQ_W-1:0]   sq_red;
  logic [SQ_W-1:0]   sq_green;
  logic [SQ_W-1:0]   sq_blue;

  // Second stage: the record handed to the next cell.
  logic              q_valid;
  item_t             q_item;
  logic [DIST_W-1:0] q_best_dist;
  logic [IDX_W-1:0]  q_best_idx;

  logic              write_hit;
  logic [DIST_W-1:0] sum_sq;
  logic              nearer;

  assign write_hit = link_in.valid && (link_in.item.cmd == CMD_WRITE) &&
                     (link_in.item.slot == cell_index);

  // Sum of squares and strict comparison, so ties keep the lower slot.
  assign sum_sq = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  assign nearer = (a_item.cmd == CMD_QUERY) && (sum_sq < a_best_dist);

  // Control state and the stored colour.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_red   <= '0;
      entry_green <= '0;
      entry_blue  <= '0;
      a_valid     <= 1'b0;
      q_valid     <= 1'b0;
    end else if (advance) begin
      if (write_hit) begin
        entry_red   <= link_in.item.red;
        entry_green <= link_in.item.green;
        entry_blue  <= link_in.item.blue;
      end
      a_valid <= link_in.valid;
      q_valid <= a_valid;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_item      <= link_in.item;
      a_best_dist <= link_in.best_dist;
      a_best_idx  <= link_in.best_idx;
      sq_red      <= sq_diff(link_in.item.red, entry_red);
      sq_green    <= sq_diff(link_in.item.green, entry_green);
      sq_blue     <= sq_diff(link_in.item.blue, entry_blue);

      q_item <= a_item;
      if (nearer) begin
        q_best_dist <= sum_sq;
        q_best_idx  <= cell_index;
      end else begin
        q_best_dist <= a_best_dist;
        q_best_idx  <= a_best_idx;
      end
    end
  end

  assign link_out.valid     = q_valid;
  assign link_out.item      = q_item;
  assign link_out.best_dist = q_best_dist;
  assign link_out.best_idx  = q_best_idx;

endmodule
